// File: design/bcg_pkg.sv
// Package with shared types and constants for the battery charge gauge.
package bcg_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [29:0] EnergyMax = 30'd999999999;
  localparam logic [47:0] ChargeMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ChargeRateReset    = 16'd6554;
  localparam logic [15:0] DischargeRateReset = 16'd7864;
  localparam logic [15:0] IdleDrawReset      = 16'd333;
  localparam logic [15:0] CapacityReset      = 16'd7330;

  // Divisors of the fold and carbon steps and their scaled reciprocals.
  localparam logic [24:0] FoldDen     = 25'd27648000;
  localparam logic [24:0] CarbonDen   = 25'd1000;
  localparam logic [31:0] FoldRecip   = 32'((64'd1 << 56) / 64'd27648000);
  localparam logic [31:0] CarbonRecip = 32'((64'd1 << 41) / 64'd1000);

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_FOLD   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_CHARGE_RATE    = 2'd0,
    REG_DISCHARGE_RATE = 2'd1,
    REG_IDLE_DRAW      = 2'd2,
    REG_CAPACITY       = 2'd3
  } reg_idx_e;

  // A classified beat as it travels from the front to the back.
  typedef struct packed {
    action_e     action;
    logic        cur_pos;
    logic [15:0] cur;
    logic [29:0] energy;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_PDIV,
    ST_PWAIT,
    ST_FOLD_MUL,
    ST_FOLD_ADD,
    ST_CARBON_MUL,
    ST_EST,
    ST_REM,
    ST_FIX,
    ST_OUT
  } state_e;

endpackage

// File: design/battery_charge_gauge.sv
// Top level of the coulomb-counting battery charge gauge.
//
//  Channel  Signals                                         Role
//  in       in_valid_i/in_ready_o, action, sample, load     action beats
//  out      out_valid_o/out_ready_i, five status fields     one status beat per action
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i                 register writes
//
// In the back stage a clear goes straight to the output state, and a load and a fold
// end with the carbon division; the fold and carbon divisions use a reciprocal
// estimate and at most one correction. A sample waits on the serial divide for the
// percentage, which is skipped at zero capacity. The queue registers each beat.
// Reset clears the gauge state and loads the register defaults.
// A two-beat queue lets the front accept beats while the back works or its result stalls.
module battery_charge_gauge
  import bcg_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] current_sample_i,
  input  logic [29:0] energy_load_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  battery_percent_o,
  output logic [31:0] raw_level_o,
  output logic [47:0] accumulated_charge_o,
  output logic [29:0] energy_wh_o,
  output logic [29:0] carbon_grams_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  bcg_front #(.QueueDepth(QueueDepth)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .current_sample_i(current_sample_i),
    .energy_load_i   (energy_load_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  bcg_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_valid_i         (cmd_valid),
    .cmd_ready_o         (cmd_ready),
    .cmd_i               (cmd),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .battery_percent_o   (battery_percent_o),
    .raw_level_o         (raw_level_o),
    .accumulated_charge_o(accumulated_charge_o),
    .energy_wh_o         (energy_wh_o),
    .carbon_grams_o      (carbon_grams_o)
  );

endmodule

// File: design/bcg_front.sv
// Front stage: accepts input beats, classifies them and queues them for the back stage.
module bcg_front
  import bcg_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] current_sample_i,
  input  logic [29:0] energy_load_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  cmd_t            new_cmd;
  logic            push, pop;

  always_comb begin
    new_cmd.action  = action_e'(action_i);
    new_cmd.cur     = current_sample_i;
    new_cmd.cur_pos = !current_sample_i[15] && (current_sample_i != 16'd0);
    new_cmd.energy  = (energy_load_i > EnergyMax) ? EnergyMax : energy_load_i;
  end

  assign in_ready_o  = (cnt_q != CntW'(QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// File: design/bcg_div.sv
// Restoring serial divider, one quotient bit per cycle.
module bcg_div
  import bcg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    quo_d = {quo_q[62:0], 1'b0};
    rem_d = trial[31:0];
    if (trial >= {1'b0, den_q}) begin
      rem_d    = 32'(trial - {1'b0, den_q});
      quo_d[0] = 1'b1;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == 7'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

endmodule

// File: design/bcg_back.sv
// Back stage: executes queued actions on the gauge state and registers the result beat.
module bcg_back
  import bcg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  battery_percent_o,
  output logic [31:0] raw_level_o,
  output logic [47:0] accumulated_charge_o,
  output logic [29:0] energy_wh_o,
  output logic [29:0] carbon_grams_o
);

  logic [15:0] crate_q, drate_q, idle_q, cap_q;
  logic [31:0] level_q, level_d;
  logic [6:0]  pct_q, pct_d;
  logic [47:0] chg_q, chg_d;
  logic [29:0] en_q, en_d;
  logic [29:0] co2_q, co2_d;
  state_e      st_q, st_d;
  cmd_t        cmd_q;
  logic [54:0] tmp_q, tmp_d;
  logic [29:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic        carb_q, carb_d;

  logic        dv_start;
  logic [63:0] dv_num;
  logic [31:0] dv_den;
  logic        dv_done;
  logic [63:0] dv_quo;

  logic signed [32:0] prod;
  logic signed [33:0] nl;
  logic [32:0]        top;
  logic [48:0]        csum;
  logic [30:0]        esum;
  logic [31:0]        est_a, est_r;
  logic [63:0]        est_p;
  logic [24:0]        cden;
  logic [54:0]        qd;
  logic [54:0]        rdiff;

  bcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .done_o (dv_done),
    .quo_o  (dv_quo)
  );

  always_comb begin
    prod  = $signed(cmd_q.cur) * $signed({1'b0, (cmd_q.cur_pos ? crate_q : drate_q)});
    top   = {1'b0, cap_q, 16'd0};
    nl    = $signed({2'b00, level_q}) + $signed(tmp_q[33:0]);
    csum  = {1'b0, chg_q} + {33'd0, cmd_q.cur};
    esum  = {1'b0, en_q} + {1'b0, quo_q};
    est_a = carb_q ? tmp_q[39:8] : tmp_q[53:22];
    est_r = carb_q ? CarbonRecip : FoldRecip;
    est_p = {32'd0, est_a} * {32'd0, est_r};
    cden  = carb_q ? CarbonDen : FoldDen;
    qd    = 55'(quo_q) * 55'(cden);
    rdiff = tmp_q - qd;
  end

  always_comb begin
    st_d        = st_q;
    level_d     = level_q;
    pct_d       = pct_q;
    chg_d       = chg_q;
    en_d        = en_q;
    co2_d       = co2_q;
    tmp_d       = tmp_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    carb_d      = carb_q;
    cmd_ready_o = 1'b0;
    dv_start    = 1'b0;
    dv_num      = 64'(level_q) * 64'd100;
    dv_den      = {cap_q, 16'd0};
    unique case (st_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_i.action)
            ACT_SAMPLE: st_d = ST_MUL;
            ACT_FOLD:   st_d = ST_FOLD_MUL;
            ACT_CLEAR: begin
              chg_d = '0;
              st_d  = ST_OUT;
            end
            ACT_LOAD: begin
              en_d = cmd_i.energy;
              st_d = ST_CARBON_MUL;
            end
            default: st_d = ST_OUT;
          endcase
        end
      end
      ST_MUL: begin
        // Arithmetic shift floors the Q8.24 product into Q16.16.
        tmp_d = 55'($signed(prod >>> 8) - $signed({1'b0, idle_q}));
        if (cmd_q.cur_pos) begin
          chg_d = csum[48] ? ChargeMax : csum[47:0];
        end
        st_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (nl < 0) begin
          level_d = '0;
        end else if (nl > $signed({1'b0, top})) begin
          level_d = top[31:0];
        end else begin
          level_d = nl[31:0];
        end
        st_d = ST_PDIV;
      end
      ST_PDIV: begin
        if (cap_q == 16'd0) begin
          pct_d = '0;
          st_d  = ST_OUT;
        end else begin
          dv_start = 1'b1;
          st_d     = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (dv_done) begin
          pct_d = dv_quo[6:0];
          st_d  = ST_OUT;
        end
      end
      ST_FOLD_MUL: begin
        tmp_d  = {7'd0, chg_q} * 55'd37;
        carb_d = 1'b0;
        st_d   = ST_EST;
      end
      ST_FOLD_ADD: begin
        en_d = (esum > {1'b0, EnergyMax}) ? EnergyMax : esum[29:0];
        st_d = ST_CARBON_MUL;
      end
      ST_CARBON_MUL: begin
        tmp_d  = {25'd0, en_q} * 55'd709 + 55'd500;
        carb_d = 1'b1;
        st_d   = ST_EST;
      end
      ST_EST: begin
        // The estimate never exceeds the true quotient and falls short by at most one.
        quo_d = carb_q ? est_p[62:33] : est_p[63:34];
        st_d  = ST_REM;
      end
      ST_REM: begin
        rem_d = rdiff[31:0];
        st_d  = ST_FIX;
      end
      ST_FIX: begin
        if (rem_q >= {7'd0, cden}) begin
          rem_d = rem_q - {7'd0, cden};
          quo_d = quo_q + 30'd1;
        end else if (carb_q) begin
          co2_d = quo_q;
          st_d  = ST_OUT;
        end else begin
          st_d = ST_FOLD_ADD;
        end
      end
      ST_OUT: begin
        if (out_ready_i || !out_valid_o) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    carb_q <= carb_d;
    if (st_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      crate_q     <= ChargeRateReset;
      drate_q     <= DischargeRateReset;
      idle_q      <= IdleDrawReset;
      cap_q       <= CapacityReset;
      level_q     <= '0;
      pct_q       <= '0;
      chg_q       <= '0;
      en_q        <= '0;
      co2_q       <= '0;
      out_valid_o <= 1'b0;
      battery_percent_o    <= '0;
      raw_level_o          <= '0;
      accumulated_charge_o <= '0;
      energy_wh_o          <= '0;
      carbon_grams_o       <= '0;
    end else begin
      st_q    <= st_d;
      level_q <= level_d;
      pct_q   <= pct_d;
      chg_q   <= chg_d;
      en_q    <= en_d;
      co2_q   <= co2_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_CHARGE_RATE:    crate_q <= cfg_data_i;
          REG_DISCHARGE_RATE: drate_q <= cfg_data_i;
          REG_IDLE_DRAW:      idle_q  <= cfg_data_i;
          REG_CAPACITY:       cap_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == ST_OUT && (out_ready_i || !out_valid_o)) begin
        out_valid_o          <= 1'b1;
        battery_percent_o    <= pct_q;
        raw_level_o          <= level_q;
        accumulated_charge_o <= chg_q;
        energy_wh_o          <= en_q;
        carbon_grams_o       <= co2_q;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
